/* rtl/lfowg_pkg.sv */
package lfowg_pkg;

  localparam int unsigned PhaseBitsDef  = 32;
  localparam int unsigned SampleBitsDef = 16;
  localparam int unsigned SineDepthDef  = 256;

  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 32;
  localparam int unsigned DelayW   = 24;
  localparam int unsigned StepW    = 32;
  localparam int unsigned RateW    = 17;
  localparam int unsigned NoiseW   = 16;
  localparam int unsigned WaveW    = 17;

  localparam logic [RateW-1:0] RateOne = 17'd65536;
  localparam longint           Q30One  = 64'sd1073741824;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_NOTE = 1'b1
  } lfowg_cmd_e;

  typedef enum logic [2:0] {
    WAVE_SINE     = 3'd0,
    WAVE_RAMP     = 3'd1,
    WAVE_DOWN     = 3'd2,
    WAVE_SQUARE   = 3'd3,
    WAVE_TRI      = 3'd4,
    WAVE_NOISE    = 3'd5,
    WAVE_OS_RAMP  = 3'd6,
    WAVE_OS_TRI   = 3'd7
  } lfowg_wave_e;

  typedef enum logic [1:0] {
    SYNC_FREE  = 2'd0,
    SYNC_RESET = 2'd1,
    SYNC_DELAY = 2'd2
  } lfowg_sync_e;

  typedef enum logic [2:0] {
    REG_ENABLE   = 3'd0,
    REG_WAVE     = 3'd1,
    REG_SYNC     = 3'd2,
    REG_DELAY    = 3'd3,
    REG_STEP     = 3'd4,
    REG_RATE     = 3'd5,
    REG_OUT_MODE = 3'd6
  } lfowg_reg_e;

  typedef struct packed {
    logic              enable;
    lfowg_wave_e       wave;
    lfowg_sync_e       sync;
    logic [DelayW-1:0] delay;
    logic [StepW-1:0]  step;
    logic [RateW-1:0]  rate;
    logic              amp_mode;
  } lfowg_cfg_t;

  // word handed from the phase stage to the smoothing stage
  typedef struct packed {
    logic                    vld;
    logic                    idle;
    logic signed [WaveW-1:0] wave;
  } lfowg_item_t;

  // quarter sine entry in Q.15 from a Q30 position t, 9th-order polynomial
  function automatic logic [15:0] sine_entry(longint t);
    longint s;
    longint r;
    longint q;
    s = (t * t) / Q30One;
    r = 64'sd172273;
    r = (r * s) / Q30One - 64'sd5026994;
    r = (r * s) / Q30One + 64'sd85569306;
    r = (r * s) / Q30One - 64'sd693598668;
    r = (r * s) / Q30One + 64'sd1686629713;
    q = (r * t) / Q30One;
    q = (q + 64'sd16384) / 64'sd32768;
    if (q < 0) q = 0;
    if (q > 32768) q = 32768;
    return q[15:0];
  endfunction

endpackage

/* rtl/lfowg_sine_lut.sv */
module lfowg_sine_lut
  import lfowg_pkg::*;
#(
  parameter int unsigned SineDepth = SineDepthDef
) (
  input  logic [14:0] pos_i,
  output logic [15:0] mag_o
);

  localparam int unsigned IdxW = $clog2(SineDepth + 1);
  localparam int unsigned PosW = 15 + IdxW;

  logic [15:0]            tab [SineDepth+1];
  logic [PosW-1:0]        pos;
  logic [IdxW-1:0]        idx_a;
  logic [IdxW-1:0]        idx_b;
  logic [13:0]            frac;
  logic [15:0]            val_a;
  logic [15:0]            val_b;
  logic signed [16:0]     diff;
  logic signed [31:0]     prod;
  logic signed [31:0]     prod_adj;
  logic signed [16:0]     interp;
  logic signed [17:0]     sum;

  for (genvar k = 0; k <= SineDepth; k++) begin : g_tab
    localparam longint T = (longint'(k) * Q30One) / SineDepth;
    if (k == 0) begin : g_zero
      assign tab[k] = 16'd0;
    end else if (k == SineDepth) begin : g_top
      assign tab[k] = 16'd32768;
    end else begin : g_mid
      assign tab[k] = sine_entry(T);
    end
  end

  assign pos   = PosW'(pos_i) * PosW'(SineDepth);
  assign idx_a = pos[14 +: IdxW];
  assign frac  = pos[13:0];
  // at the end of the quarter the fraction is zero, so the second read is unused
  assign idx_b = (idx_a == IdxW'(SineDepth)) ? idx_a : idx_a + 1'b1;
  assign val_a = tab[idx_a];
  assign val_b = tab[idx_b];

  assign diff     = $signed({1'b0, val_b}) - $signed({1'b0, val_a});
  assign prod     = 32'(diff) * 32'($signed({1'b0, frac}));
  // truncate toward zero
  assign prod_adj = prod[31] ? prod + 32'sd16383 : prod;
  assign interp   = prod_adj[30:14];
  assign sum      = $signed({2'b00, val_a}) + 18'(interp);
  assign mag_o    = sum[15:0];

endmodule

/* rtl/lfowg_phase.sv */
module lfowg_phase
  import lfowg_pkg::*;
#(
  parameter int unsigned PhaseBits = PhaseBitsDef,
  parameter int unsigned SineDepth = SineDepthDef
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  lfowg_cfg_t               cfg_i,
  input  logic                     in_acc_i,
  input  logic                     command_i,
  input  logic signed [NoiseW-1:0] noise_i,
  input  logic                     adv_i,
  output lfowg_item_t              item_o
);

  localparam int unsigned SumW = ((PhaseBits > StepW) ? PhaseBits : StepW) + 1;

  logic [PhaseBits-1:0]     phase_q, phase_d;
  logic [DelayW-1:0]        delay_q, delay_d;
  logic                     wrap_q, wrap_d;
  logic signed [NoiseW-1:0] noise_q, noise_d;
  lfowg_item_t              item_q, item_d;

  logic [SumW-1:0]          sum;
  logic                     carry;
  logic [PhaseBits-1:0]     phase_nxt;
  logic [15:0]              u;
  logic signed [17:0]       uext;
  logic signed [NoiseW-1:0] noise_sel;
  logic [14:0]              sine_pos;
  logic [15:0]              sine_mag;
  logic signed [17:0]       raw;
  logic signed [WaveW-1:0]  wave_val;
  logic                     oneshot;
  logic [DelayW-1:0]        delay_dec;

  assign sum       = SumW'(phase_q) + SumW'(cfg_i.step);
  assign carry     = |sum[SumW-1:PhaseBits];
  assign phase_nxt = sum[PhaseBits-1:0];
  assign u         = phase_nxt[PhaseBits-1 -: 16];
  assign uext      = $signed({2'b00, u});
  assign noise_sel = carry ? noise_i : noise_q;
  assign oneshot   = (cfg_i.wave == WAVE_OS_RAMP) || (cfg_i.wave == WAVE_OS_TRI);
  assign delay_dec = (delay_q != '0) ? delay_q - 1'b1 : delay_q;

  // second and fourth quarters read the table mirrored
  assign sine_pos = u[14] ? (15'd16384 - {1'b0, u[13:0]}) : {1'b0, u[13:0]};

  lfowg_sine_lut #(
    .SineDepth(SineDepth)
  ) u_sine (
    .pos_i(sine_pos),
    .mag_o(sine_mag)
  );

  always_comb begin
    case (cfg_i.wave)
      WAVE_SINE: begin
        raw = u[15] ? -$signed({2'b00, sine_mag}) : $signed({2'b00, sine_mag});
      end
      WAVE_RAMP: begin
        raw = 18'($signed(u));
      end
      WAVE_DOWN: begin
        raw = 18'sd32768 - uext;
      end
      WAVE_SQUARE: begin
        raw = u[15] ? -18'sd32768 : 18'sd32768;
      end
      WAVE_TRI: begin
        if (u < 16'd16384) begin
          raw = uext <<< 1;
        end else if (u < 16'd49152) begin
          raw = 18'sd65536 - (uext <<< 1);
        end else begin
          raw = ((uext - 18'sd49152) <<< 1) - 18'sd32768;
        end
      end
      WAVE_NOISE: begin
        raw = 18'(noise_sel);
      end
      WAVE_OS_RAMP: begin
        raw = u[15] ? 18'sd0 : 18'sd32768 - uext;
      end
      WAVE_OS_TRI: begin
        if (u < 16'd16384) begin
          raw = uext <<< 1;
        end else if (u < 16'd32768) begin
          raw = 18'sd65536 - (uext <<< 1);
        end else begin
          raw = 18'sd0;
        end
      end
      default: begin
        raw = 18'sd0;
      end
    endcase
  end

  assign wave_val = raw[WaveW-1:0];

  always_comb begin
    phase_d    = phase_q;
    delay_d    = delay_q;
    wrap_d     = wrap_q;
    noise_d    = noise_q;
    item_d     = item_q;
    item_d.vld = item_q.vld && !adv_i;
    if (in_acc_i) begin
      if (command_i == CMD_NOTE) begin
        wrap_d = 1'b0;
        case (cfg_i.sync)
          SYNC_FREE: begin
            delay_d = '0;
            if (oneshot) phase_d = '0;
          end
          SYNC_RESET: begin
            phase_d = '0;
            delay_d = '0;
          end
          default: begin
            phase_d = '0;
            delay_d = cfg_i.delay;
          end
        endcase
      end else begin
        item_d.vld  = 1'b1;
        item_d.idle = !cfg_i.enable;
        item_d.wave = '0;
        if (cfg_i.enable) begin
          delay_d = delay_dec;
          if (delay_dec == '0) begin
            phase_d = phase_nxt;
            if (carry) begin
              noise_d = noise_i;
              wrap_d  = 1'b1;
            end
            // one-shot shapes fall silent from the wrapping tick on
            item_d.wave = (oneshot && (wrap_q || carry)) ? '0 : wave_val;
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= '0;
      delay_q <= '0;
      wrap_q  <= 1'b0;
      noise_q <= '0;
      item_q  <= '0;
    end else begin
      phase_q <= phase_d;
      delay_q <= delay_d;
      wrap_q  <= wrap_d;
      noise_q <= noise_d;
      item_q  <= item_d;
    end
  end

  assign item_o = item_q;

endmodule

/* rtl/lfowg_smooth.sv */
module lfowg_smooth
  import lfowg_pkg::*;
#(
  parameter int unsigned SampleBits = SampleBitsDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  lfowg_cfg_t                   cfg_i,
  input  lfowg_item_t                  item_i,
  input  logic                         adv_i,
  output logic                         out_vld_o,
  output logic signed [SampleBits-1:0] sample_o
);

  localparam int unsigned       OutShift = 31 - SampleBits;
  localparam logic signed [33:0] OutMax  = (34'sd1 <<< (SampleBits - 1)) - 34'sd1;
  localparam logic signed [33:0] OutMin  = -OutMax - 34'sd1;

  logic signed [31:0]           level_q, level_nxt;
  logic                         out_vld_q;
  logic signed [SampleBits-1:0] sample_q, sample_d;

  logic [RateW-1:0]             rate;
  logic signed [33:0]           target;
  logic signed [33:0]           diff;
  logic signed [51:0]           prod;

  // floor to the sample grid, then saturate
  function automatic logic signed [SampleBits-1:0] to_out(logic signed [33:0] x);
    logic signed [33:0] sh;
    sh = x >>> OutShift;
    if (sh > OutMax) return OutMax[SampleBits-1:0];
    if (sh < OutMin) return OutMin[SampleBits-1:0];
    return sh[SampleBits-1:0];
  endfunction

  assign rate      = (cfg_i.rate > RateOne) ? RateOne : cfg_i.rate;
  assign target    = 34'(item_i.wave) <<< 15;
  assign diff      = target - 34'(level_q);
  assign prod      = 52'(diff) * 52'($signed({1'b0, rate}));
  assign level_nxt = level_q + prod[47:16];

  always_comb begin
    if (item_i.idle) begin
      sample_d = cfg_i.amp_mode ? OutMax[SampleBits-1:0] : '0;
    end else if (cfg_i.amp_mode) begin
      sample_d = to_out(34'(level_nxt));
    end else begin
      sample_d = to_out(target);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
      level_q   <= '0;
    end else if (adv_i) begin
      out_vld_q <= item_i.vld;
      if (item_i.vld && !item_i.idle && cfg_i.amp_mode) level_q <= level_nxt;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && item_i.vld) sample_q <= sample_d;
  end

  assign out_vld_o = out_vld_q;
  assign sample_o  = sample_q;

endmodule

/* rtl/lfo_wave_generator_sync_delay_unit.sv */
// channel  | valid / ready            | payload
// ---------+--------------------------+--------------------------------------
// in       | in_valid_i / in_ready_o  | command_i, noise_value_i
// out      | out_valid_o / out_ready_i| lfo_sample_o
// cfg      | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// one word per cycle in and out unless out stalls; a taken tick reaches out via
// stage one (phase, delay and noise state), then stage two (smoother and output)
// a note-on updates stage one only and gives no word on out
// out stalls hold the output register; in_ready_o drops only when both stages are full
// reset loads the register defaults and clears all oscillator state, no clearing pass
module lfo_wave_generator_sync_delay_unit
  import lfowg_pkg::*;
#(
  parameter int unsigned PhaseBits  = PhaseBitsDef,
  parameter int unsigned SampleBits = SampleBitsDef,
  parameter int unsigned SineDepth  = SineDepthDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic                         command_i,
  input  logic signed [NoiseW-1:0]     noise_value_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic signed [SampleBits-1:0] lfo_sample_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [CfgIdxW-1:0]           cfg_index_i,
  input  logic [CfgDataW-1:0]          cfg_data_i
);

  lfowg_cfg_t  cfg_q;
  lfowg_item_t item;
  logic        out_adv;
  logic        in_acc;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enable   <= 1'b0;
      cfg_q.wave     <= WAVE_SINE;
      cfg_q.sync     <= SYNC_FREE;
      cfg_q.delay    <= '0;
      cfg_q.step     <= '0;
      cfg_q.rate     <= RateOne;
      cfg_q.amp_mode <= 1'b0;
    end else if (cfg_valid_i) begin
      case (lfowg_reg_e'(cfg_index_i))
        REG_ENABLE:   cfg_q.enable   <= cfg_data_i[0];
        REG_WAVE:     cfg_q.wave     <= lfowg_wave_e'(cfg_data_i[2:0]);
        REG_SYNC:     cfg_q.sync     <= lfowg_sync_e'(cfg_data_i[1:0]);
        REG_DELAY:    cfg_q.delay    <= cfg_data_i[DelayW-1:0];
        REG_STEP:     cfg_q.step     <= cfg_data_i[StepW-1:0];
        REG_RATE:     cfg_q.rate     <= cfg_data_i[RateW-1:0];
        REG_OUT_MODE: cfg_q.amp_mode <= cfg_data_i[0];
        default: begin
        end
      endcase
    end
  end

  assign out_adv    = !out_valid_o || out_ready_i;
  assign in_ready_o = !item.vld || out_adv;
  assign in_acc     = in_valid_i && in_ready_o;

  lfowg_phase #(
    .PhaseBits(PhaseBits),
    .SineDepth(SineDepth)
  ) u_phase (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .in_acc_i (in_acc),
    .command_i(command_i),
    .noise_i  (noise_value_i),
    .adv_i    (out_adv),
    .item_o   (item)
  );

  lfowg_smooth #(
    .SampleBits(SampleBits)
  ) u_smooth (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg_q),
    .item_i   (item),
    .adv_i    (out_adv),
    .out_vld_o(out_valid_o),
    .sample_o (lfo_sample_o)
  );

  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item.vld && !out_adv) |=> (item.vld && $stable(item)))
    else $error("stage word changed while stalled");

  a_note_no_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && (command_i == CMD_NOTE) && out_adv) |=> !item.vld)
    else $error("note-on produced a stage word");

  a_empty_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !item.vld |-> in_ready_o)
    else $error("input blocked with an empty stage");

endmodule
